### src/dsc_pkg.sv
// ----------------------------------------------------------------------------
// dsc_pkg
// Shared types and constants of the deep sample compositor.
// ----------------------------------------------------------------------------
package dsc_pkg;

    // opacity of one in unsigned Q1.16
    localparam logic [16:0] ALPHA_ONE = 17'd65536;

    // configuration address width and register indexes (word address bits)
    localparam int unsigned CFG_ADDR_W = 4;
    localparam logic [1:0] REG_DEPTH_MIN  = 2'd0;
    localparam logic [1:0] REG_DEPTH_MAX  = 2'd1;
    localparam logic [1:0] REG_DEPTH_ONLY = 2'd2;

    // input and output stream payload widths
    localparam int unsigned S_TDATA_W = 128;
    localparam int unsigned M_TDATA_W = 152;

    typedef struct packed {
        logic signed [31:0] depth;
        logic               depth_finite;
        logic signed [23:0] red;
        logic signed [23:0] green;
        logic signed [23:0] blue;
        logic        [16:0] alpha;
        logic               last_of_pixel;
    } t_sample;

    typedef struct packed {
        logic signed [31:0] depth_min;
        logic signed [31:0] depth_max;
        logic               depth_only;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] red_sum;
        logic signed [31:0] green_sum;
        logic signed [31:0] blue_sum;
        logic        [16:0] alpha_sum;
        logic               covered;
        logic signed [31:0] first_depth;
    } t_result;

endpackage

### src/deep_sample_compositor.sv
// ----------------------------------------------------------------------------
// deep_sample_compositor
// Front-to-back over compositing of the deep samples of one pixel, or its first in-window depth in depth-only mode.
// ----------------------------------------------------------------------------
// a pixel's result word is registered in the result register after its last sample leaves the input register
// throughput: one sample per cycle but for the stall below; the accumulator loop is not pipelined
// a result stalled at the output holds only a last sample and those behind it; others keep flowing
// reset (synchronous, active low) clears the pipeline and pixel state and sets
// the depth window to the full range with depth-only mode off
// ----------------------------------------------------------------------------
module deep_sample_compositor
    import dsc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,  // depth, red, green, blue, alpha, zero fill
    input  logic                  s_tuser,  // depth_finite
    input  logic                  s_tlast,  // last_of_pixel
    // master stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,  // red_sum, green_sum, blue_sum, alpha_sum,
                                            // first_depth, zero fill
    output logic                  m_tuser,  // covered
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    t_cfg    w_cfg;
    t_sample r_s1;
    logic    r_s1_valid;
    logic    w_out_free;
    logic    w_s1_adv;
    logic    w_s_acc;
    t_result w_res;
    t_result r_out;
    logic    r_out_valid;

    assign pready = 1'b1;

    dsc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (w_cfg)
    );

    // flow control: a sample with no result never waits on the output
    assign w_out_free = !r_out_valid || m_tready;
    assign w_s1_adv   = r_s1_valid && (!r_s1.last_of_pixel || w_out_free);
    assign s_tready   = !r_s1_valid || w_s1_adv;
    assign w_s_acc    = s_tvalid && s_tready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_tready) begin
            r_s1_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_s1.depth         <= s_tdata[31:0];
            r_s1.red           <= s_tdata[55:32];
            r_s1.green         <= s_tdata[79:56];
            r_s1.blue          <= s_tdata[103:80];
            r_s1.alpha         <= s_tdata[120:104];
            r_s1.depth_finite  <= s_tuser;
            r_s1.last_of_pixel <= s_tlast;
        end
    end

    dsc_acc u_acc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_s1_adv),
        .i_sample (r_s1),
        .i_cfg    (w_cfg),
        .o_result (w_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_s1_adv && r_s1.last_of_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_s1_adv && r_s1.last_of_pixel) begin
            r_out <= w_res;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tuser  = r_out.covered;
    assign m_tdata  = {7'd0, r_out.first_depth, r_out.alpha_sum, r_out.blue_sum,
                       r_out.green_sum, r_out.red_sum};

    // an uncovered pixel reports all zeros
    a_uncovered_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("uncovered pixel with nonzero result");

    // accumulated opacity never exceeds one
    a_alpha_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (r_out.alpha_sum <= ALPHA_ONE))
        else $error("alpha sum above one");

    // depth and color results are never reported together
    a_mode_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && (r_out.first_depth != 32'sd0)) |->
        ((r_out.red_sum == 32'sd0) && (r_out.alpha_sum == 17'd0)))
        else $error("depth and color result mixed");

endmodule

### src/dsc_cfg.sv
// ----------------------------------------------------------------------------
// dsc_cfg
// APB register bank: depth window and depth-only mode.
// ----------------------------------------------------------------------------
module dsc_cfg
    import dsc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output t_cfg                  o_cfg
);

    logic        w_wr;
    logic [1:0]  w_idx;
    t_cfg        r_cfg;

    assign w_wr  = psel & penable & pwrite;
    assign w_idx = paddr[3:2];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.depth_min  <= 32'sh8000_0000;
            r_cfg.depth_max  <= 32'sh7fff_ffff;
            r_cfg.depth_only <= 1'b0;
        end else if (w_wr) begin
            case (w_idx)
                REG_DEPTH_MIN:  r_cfg.depth_min  <= pwdata;
                REG_DEPTH_MAX:  r_cfg.depth_max  <= pwdata;
                REG_DEPTH_ONLY: r_cfg.depth_only <= pwdata[0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (w_idx)
            REG_DEPTH_MIN:  prdata = r_cfg.depth_min;
            REG_DEPTH_MAX:  prdata = r_cfg.depth_max;
            REG_DEPTH_ONLY: prdata = {31'd0, r_cfg.depth_only};
            default:        prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

### src/dsc_acc.sv
// ----------------------------------------------------------------------------
// dsc_acc
// Per-pixel front-to-back over accumulator; one sample per enabled cycle.
// ----------------------------------------------------------------------------
module dsc_acc
    import dsc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_sample i_sample,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    logic signed [31:0] r_red, r_green, r_blue, r_held;
    logic        [16:0] r_alpha;
    logic               r_cov;

    logic signed [31:0] n_red, n_green, n_blue, n_held;
    logic        [16:0] n_alpha;
    logic               n_cov;

    logic signed [31:0] u_red, u_green, u_blue, u_held;
    logic        [16:0] u_alpha;
    logic               u_cov;

    logic        [16:0] w_a;
    logic        [16:0] w_t;
    logic               w_in;
    logic        [33:0] w_pa;
    logic        [17:0] w_da;
    logic        [18:0] w_asum;

    // (t * c + half) >> 16 added to the sum, saturated to 32 bits
    function automatic logic signed [31:0] over_add(
        input logic signed [31:0] acc,
        input logic        [16:0] t,
        input logic signed [23:0] c
    );
        logic signed [41:0] prod;
        logic signed [41:0] sum;
        prod = $signed({1'b0, t}) * c;
        prod = prod + 42'sd32768;
        sum  = $signed({{10{acc[31]}}, acc}) + (prod >>> 16);
        if (sum > 42'sd2147483647)
            over_add = 32'sh7fff_ffff;
        else if (sum < -42'sd2147483648)
            over_add = 32'sh8000_0000;
        else
            over_add = sum[31:0];
    endfunction

    // sample qualification and opacity terms
    always_comb begin
        w_a    = (i_sample.alpha > ALPHA_ONE) ? ALPHA_ONE : i_sample.alpha;
        w_in   = i_sample.depth_finite && (i_sample.depth >= i_cfg.depth_min)
                 && (i_sample.depth <= i_cfg.depth_max);
        w_t    = ALPHA_ONE - r_alpha;
        w_pa   = {17'd0, w_t} * {17'd0, w_a};
        w_da   = 18'((w_pa + 34'd32768) >> 16);
        w_asum = {2'd0, r_alpha} + {1'b0, w_da};
    end

    // accumulator update
    always_comb begin
        u_red   = r_red;
        u_green = r_green;
        u_blue  = r_blue;
        u_alpha = r_alpha;
        u_cov   = r_cov;
        u_held  = r_held;
        if (w_in) begin
            if (!r_cov && i_cfg.depth_only)
                u_held = i_sample.depth;
            u_cov = 1'b1;
            if (!i_cfg.depth_only && (r_alpha < ALPHA_ONE)) begin
                u_red   = over_add(r_red,   w_t, i_sample.red);
                u_green = over_add(r_green, w_t, i_sample.green);
                u_blue  = over_add(r_blue,  w_t, i_sample.blue);
                u_alpha = (w_asum > {2'd0, ALPHA_ONE}) ? ALPHA_ONE : w_asum[16:0];
            end
        end
    end

    // result of the pixel as it stands after this sample
    always_comb begin
        o_result = '0;
        if (u_cov) begin
            o_result.covered = 1'b1;
            if (i_cfg.depth_only) begin
                o_result.first_depth = u_held;
            end else begin
                o_result.red_sum   = u_red;
                o_result.green_sum = u_green;
                o_result.blue_sum  = u_blue;
                o_result.alpha_sum = u_alpha;
            end
        end
    end

    // clear after the last sample of a pixel
    always_comb begin
        if (i_sample.last_of_pixel) begin
            n_red = '0; n_green = '0; n_blue = '0;
            n_alpha = '0; n_cov = 1'b0; n_held = '0;
        end else begin
            n_red = u_red; n_green = u_green; n_blue = u_blue;
            n_alpha = u_alpha; n_cov = u_cov; n_held = u_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red   <= '0;
            r_green <= '0;
            r_blue  <= '0;
            r_alpha <= '0;
            r_cov   <= 1'b0;
            r_held  <= '0;
        end else if (i_step) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
            r_alpha <= n_alpha;
            r_cov   <= n_cov;
            r_held  <= n_held;
        end
    end

endmodule
